// File: hw/rtl/ils_pkg.sv
// Shared types and constants for the indexed list store.
`default_nettype none
package ils_pkg;

   localparam int ACT_W    = 3;
   localparam int POS_W    = 16;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 7;

   localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
   localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_TAIL   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic signed [DATA_W-1:0] READ_ERR_VALUE = -32'sd1;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_READ_ADDR,
      SEQ_READ_DATA,
      SEQ_MOVE,
      SEQ_DRAIN,
      SEQ_PLACE,
      SEQ_DONE
   } state_type;

   // Job handed from the request decode to the sequencer.
   typedef struct packed {
      logic start;
      logic is_read;
      logic do_move;
      logic do_place;
      logic move_up;
   } cmd_type;

   // Sequencer status and memory write control.
   typedef struct packed {
      logic idle;
      logic finish;
      logic rd_capture;
      logic wr_en;
      logic wr_value;
   } stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/indexed_list_store.sv
// Top level of the indexed list store: request decode, count, result register.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/ready    action, position, value
//   rsp_     out        rsp_valid/ready    read_value, status, entry_total
//
// Errors and unused actions complete at acceptance; the result shows in the next cycle.
// A read steps through address, registered RAM read and capture.
// Insert/remove move one entry per cycle through the single RAM port pair;
// after the moves the last write drains, then the new value is placed (insert).
// Reset clears the count and the control; entry contents are left as is.
// A new request is taken only when idle and the result register is free or
// being taken in the same cycle.
`default_nettype none
module indexed_list_store #(
   parameter int CAPACITY = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [ils_pkg::ACT_W-1:0]            req_action,
   input  wire logic [ils_pkg::POS_W-1:0]            req_position,
   input  wire logic signed [ils_pkg::DATA_W-1:0]    req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [ils_pkg::DATA_W-1:0]         rsp_read_value,
   output logic [ils_pkg::STATUS_W-1:0]              rsp_status,
   output logic [ils_pkg::TOTAL_W-1:0]               rsp_entry_total
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;

   ils_pkg::cmd_type  cmd;
   ils_pkg::stat_type stat;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             grow_ff, grow_in;
   logic             shrink_ff, shrink_in;
   logic signed [ils_pkg::DATA_W-1:0] value_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [ils_pkg::DATA_W-1:0] rd_val_ff, rd_val_in;
   logic [ils_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [ils_pkg::TOTAL_W-1:0]       total_ff, total_in;

   logic [AW-1:0] src_start, src_last, place_addr;
   logic [AW-1:0] ram_rd_addr, ram_wr_addr;
   logic [ils_pkg::DATA_W-1:0] ram_rd_data, ram_wr_data;

   logic                 accept;
   logic                 full;
   logic [CMP_W-1:0]     pos_cmp, cnt_cmp, pos_inc;
   logic [CNT_W-1:0]     cnt_dec;
   logic [CNT_W+ils_pkg::TOTAL_W-1:0] total_wide;

   assign req_ready = stat.idle && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign pos_cmp = CMP_W'({{CNT_W{1'b0}}, req_position});
   assign cnt_cmp = CMP_W'({{ils_pkg::POS_W{1'b0}}, count_ff});
   assign pos_inc = pos_cmp + 1'b1;
   assign cnt_dec = count_ff - 1'b1;
   assign full    = (count_ff == CNT_W'(CAPACITY));

   // Decode the request; errors and unused actions finish right away.
   always_comb begin
      cmd          = '0;
      src_start    = req_position[AW-1:0];
      src_last     = req_position[AW-1:0];
      place_addr   = req_position[AW-1:0];
      grow_in      = grow_ff;
      shrink_in    = shrink_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_val_in    = rd_val_ff;
      status_in    = status_ff;
      total_wide   = {{ils_pkg::TOTAL_W{1'b0}}, count_ff};
      total_in     = total_ff;
      count_in     = count_ff;

      if (accept) begin
         grow_in   = 1'b0;
         shrink_in = 1'b0;
         rd_val_in = '0;
         status_in = ils_pkg::ST_DONE;
         total_in  = total_wide[ils_pkg::TOTAL_W-1:0];
         case (req_action)
            ils_pkg::ACT_READ: begin
               if (pos_cmp < cnt_cmp) begin
                  cmd.start   = 1'b1;
                  cmd.is_read = 1'b1;
               end else begin
                  rsp_valid_in = 1'b1;
                  rd_val_in    = ils_pkg::READ_ERR_VALUE;
                  status_in    = ils_pkg::ST_RANGE;
               end
            end
            ils_pkg::ACT_INSERT, ils_pkg::ACT_HEAD, ils_pkg::ACT_TAIL: begin
               if (req_action == ils_pkg::ACT_HEAD) begin
                  place_addr = '0;
               end else if (req_action == ils_pkg::ACT_TAIL) begin
                  place_addr = count_ff[AW-1:0];
               end
               src_start = cnt_dec[AW-1:0];
               src_last  = place_addr;
               if (req_action == ils_pkg::ACT_INSERT && pos_cmp > cnt_cmp) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ils_pkg::ST_RANGE;
               end else if (full) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ils_pkg::ST_FULL;
               end else begin
                  cmd.start    = 1'b1;
                  cmd.do_place = 1'b1;
                  cmd.move_up  = 1'b1;
                  cmd.do_move  = (req_action == ils_pkg::ACT_HEAD)
                                 ? (count_ff != '0)
                                 : (req_action == ils_pkg::ACT_INSERT)
                                    && (pos_cmp < cnt_cmp);
                  grow_in      = 1'b1;
               end
            end
            ils_pkg::ACT_REMOVE: begin
               src_start = req_position[AW-1:0] + 1'b1;
               src_last  = cnt_dec[AW-1:0];
               if (pos_cmp >= cnt_cmp) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ils_pkg::ST_RANGE;
               end else begin
                  cmd.start = 1'b1;
                  cmd.do_move = (pos_inc < cnt_cmp);
                  shrink_in = 1'b1;
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end else if (stat.finish) begin
         if (grow_ff) begin
            count_in = count_ff + 1'b1;
         end else if (shrink_ff) begin
            count_in = cnt_dec;
         end
         total_wide   = {{ils_pkg::TOTAL_W{1'b0}}, count_in};
         rsp_valid_in = 1'b1;
         rd_val_in    = stat.rd_capture ? ram_rd_data : '0;
         status_in    = ils_pkg::ST_DONE;
         total_in     = total_wide[ils_pkg::TOTAL_W-1:0];
      end
   end

   assign ram_wr_data = stat.wr_value ? value_ff : ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         grow_ff      <= 1'b0;
         shrink_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         grow_ff      <= grow_in;
         shrink_ff    <= shrink_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         value_ff <= req_value;
      end
      rd_val_ff <= rd_val_in;
      status_ff <= status_in;
      total_ff  <= total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rd_val_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_total = total_ff;

   ils_seq #(
      .AW(AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .src_start  (src_start),
      .src_last   (src_last),
      .place_addr (place_addr),
      .stat       (stat),
      .rd_addr    (ram_rd_addr),
      .wr_addr    (ram_wr_addr)
   );

   ils_ram #(
      .WIDTH(ils_pkg::DATA_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (stat.wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

// File: hw/rtl/ils_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ils_seq.sv
// Sequencer: walks the entry cursor for reads, shifts and the final placement.
`default_nettype none
module ils_seq #(
   parameter int AW = 6
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ils_pkg::cmd_type cmd,
   input  wire logic [AW-1:0]   src_start,
   input  wire logic [AW-1:0]   src_last,
   input  wire logic [AW-1:0]   place_addr,
   output ils_pkg::stat_type    stat,
   output logic [AW-1:0]        rd_addr,
   output logic [AW-1:0]        wr_addr
);

   ils_pkg::state_type state_ff, state_in;
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic [AW-1:0] place_ff, place_in;
   logic          pend_ff, pend_in;
   logic          up_ff, up_in;
   logic          place_en_ff, place_en_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ils_pkg::SEQ_IDLE: begin
            if (cmd.start) begin
               if (cmd.is_read) begin
                  state_in = ils_pkg::SEQ_READ_ADDR;
               end else if (cmd.do_move) begin
                  state_in = ils_pkg::SEQ_MOVE;
               end else if (cmd.do_place) begin
                  state_in = ils_pkg::SEQ_PLACE;
               end else begin
                  state_in = ils_pkg::SEQ_DONE;
               end
            end
         end
         ils_pkg::SEQ_READ_ADDR: state_in = ils_pkg::SEQ_READ_DATA;
         ils_pkg::SEQ_READ_DATA: state_in = ils_pkg::SEQ_IDLE;
         ils_pkg::SEQ_MOVE: begin
            if (src_ff == last_ff) begin
               state_in = ils_pkg::SEQ_DRAIN;
            end
         end
         ils_pkg::SEQ_DRAIN: begin
            state_in = place_en_ff ? ils_pkg::SEQ_PLACE : ils_pkg::SEQ_DONE;
         end
         ils_pkg::SEQ_PLACE: state_in = ils_pkg::SEQ_DONE;
         ils_pkg::SEQ_DONE:  state_in = ils_pkg::SEQ_IDLE;
         default:            state_in = ils_pkg::SEQ_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      stat = '0;
      case (state_ff)
         ils_pkg::SEQ_IDLE:      stat.idle = 1'b1;
         ils_pkg::SEQ_READ_ADDR: stat.idle = 1'b0;
         ils_pkg::SEQ_READ_DATA: begin
            stat.finish     = 1'b1;
            stat.rd_capture = 1'b1;
         end
         ils_pkg::SEQ_MOVE:  stat.wr_en = pend_ff;
         ils_pkg::SEQ_DRAIN: stat.wr_en = 1'b1;
         ils_pkg::SEQ_PLACE: begin
            stat.wr_en    = 1'b1;
            stat.wr_value = 1'b1;
         end
         ils_pkg::SEQ_DONE: stat.finish = 1'b1;
         default:           stat.idle = 1'b0;
      endcase
   end

   assign rd_addr = src_ff;
   assign wr_addr = (state_ff == ils_pkg::SEQ_PLACE) ? place_ff : dst_ff;

   // Cursor: read one entry a cycle, write it one slot over in the next cycle.
   always_comb begin
      src_in      = src_ff;
      last_in     = last_ff;
      dst_in      = dst_ff;
      place_in    = place_ff;
      pend_in     = pend_ff;
      up_in       = up_ff;
      place_en_in = place_en_ff;
      if (state_ff == ils_pkg::SEQ_IDLE && cmd.start) begin
         src_in      = src_start;
         last_in     = src_last;
         place_in    = place_addr;
         up_in       = cmd.move_up;
         place_en_in = cmd.do_place;
         pend_in     = 1'b0;
      end else if (state_ff == ils_pkg::SEQ_MOVE) begin
         pend_in = 1'b1;
         dst_in  = up_ff ? src_ff + 1'b1 : src_ff - 1'b1;
         src_in  = up_ff ? src_ff - 1'b1 : src_ff + 1'b1;
      end else if (state_ff == ils_pkg::SEQ_DRAIN) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ils_pkg::SEQ_IDLE;
         pend_ff     <= 1'b0;
         up_ff       <= 1'b0;
         place_en_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         up_ff       <= up_in;
         place_en_ff <= place_en_in;
      end
      src_ff   <= src_in;
      last_ff  <= last_in;
      dst_ff   <= dst_in;
      place_ff <= place_in;
   end

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the indexed list store: directed table, then biased random traffic.
`timescale 1ns / 1ps
module testbench;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int N_ROWS       = 20;
   localparam int PRINT_CAP    = 60;

   localparam logic [ils_pkg::ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [ils_pkg::ACT_W-1:0] ACT_SPARE_MID = 3'd6;
   localparam logic [ils_pkg::ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_type;

   typedef struct packed {
      logic signed [ils_pkg::DATA_W-1:0] read_value;
      logic [ils_pkg::STATUS_W-1:0]      status;
      logic [ils_pkg::TOTAL_W-1:0]       entry_total;
   } list_result_type;

   typedef struct packed {
      logic [ils_pkg::ACT_W-1:0]         action;
      logic [ils_pkg::POS_W-1:0]         position;
      logic signed [ils_pkg::DATA_W-1:0] value;
      logic                              typed;
      list_result_type                   result;
   } step_row_type;

   localparam list_result_type NO_RESULT = '0;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [ils_pkg::ACT_W-1:0]         req_action = ils_pkg::ACT_READ;
   logic [ils_pkg::POS_W-1:0]         req_position = '0;
   logic signed [ils_pkg::DATA_W-1:0] req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [ils_pkg::DATA_W-1:0] rsp_read_value;
   logic [ils_pkg::STATUS_W-1:0]      rsp_status;
   logic [ils_pkg::TOTAL_W-1:0]       rsp_entry_total;

   indexed_list_store #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value),
      .rsp_status(rsp_status),
      .rsp_entry_total(rsp_entry_total)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the list and the results still owed by the block.
   logic signed [ils_pkg::DATA_W-1:0] shadow_list [CAPACITY];
   int                                shadow_count = 0;
   list_result_type                   pending_results [$];

   bit calm = 1'b0;
   int mismatch_count = 0;
   int n_results = 0;
   int n_full = 0;
   int n_range = 0;
   int peak_count = 0;
   int cycle_count = 0;
   int rsp_hold = 0;

   step_row_type directed_rows [N_ROWS];

   task automatic report_mismatch(input string what,
                                  input logic [ils_pkg::DATA_W-1:0] got,
                                  input logic [ils_pkg::DATA_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("[%0t] mismatch on %0s: got %h, want %h (result %0d)",
                  $realtime, what, got, want, n_results);
      end
   endtask

   function automatic logic [ils_pkg::STATUS_W-1:0] list_put(
         input int at, input logic signed [ils_pkg::DATA_W-1:0] val);
      int i;
      if (shadow_count >= CAPACITY) begin
         return ils_pkg::ST_FULL;
      end
      for (i = shadow_count; i > at; i--) begin
         shadow_list[i] = shadow_list[i-1];
      end
      shadow_list[at] = val;
      shadow_count++;
      return ils_pkg::ST_DONE;
   endfunction

   function automatic list_result_type list_apply(
         input logic [ils_pkg::ACT_W-1:0] act,
         input logic [ils_pkg::POS_W-1:0] pos,
         input logic signed [ils_pkg::DATA_W-1:0] val);
      list_result_type r;
      int              p;
      int              i;
      r = NO_RESULT;
      r.status = ils_pkg::ST_DONE;
      p = int'(pos);
      case (act)
         ils_pkg::ACT_READ: begin
            if (p < shadow_count) begin
               r.read_value = shadow_list[p];
            end else begin
               r.read_value = ils_pkg::READ_ERR_VALUE;
               r.status = ils_pkg::ST_RANGE;
            end
         end
         ils_pkg::ACT_INSERT: begin
            // range check wins over the full check
            if (p > shadow_count) begin
               r.status = ils_pkg::ST_RANGE;
            end else begin
               r.status = list_put(p, val);
            end
         end
         ils_pkg::ACT_HEAD: r.status = list_put(0, val);
         ils_pkg::ACT_TAIL: r.status = list_put(shadow_count, val);
         ils_pkg::ACT_REMOVE: begin
            if (p >= shadow_count) begin
               r.status = ils_pkg::ST_RANGE;
            end else begin
               for (i = p; i + 1 < shadow_count; i++) begin
                  shadow_list[i] = shadow_list[i+1];
               end
               shadow_count--;
            end
         end
         default: ;
      endcase
      r.entry_total = shadow_count[ils_pkg::TOTAL_W-1:0];
      return r;
   endfunction

   // Drive one request, wait for its beat, then log what the block owes for it.
   task automatic issue_step(input step_row_type s);
      int              gap;
      list_result_type predicted;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= s.action;
      req_position <= s.position;
      req_value    <= s.value;
      do @(posedge clock); while (!req_ready);
      predicted = list_apply(s.action, s.position, s.value);
      if (s.typed) begin
         predicted = s.result;
      end
      if (predicted.status == ils_pkg::ST_FULL) n_full++;
      if (predicted.status == ils_pkg::ST_RANGE) n_range++;
      if (shadow_count > peak_count) peak_count = shadow_count;
      pending_results.push_back(predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_read_value, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", ils_pkg::DATA_W'(rsp_status),
                                  ils_pkg::DATA_W'(want.status));
               end
               if (rsp_entry_total !== want.entry_total) begin
                  report_mismatch("entry_total", ils_pkg::DATA_W'(rsp_entry_total),
                                  ils_pkg::DATA_W'(want.entry_total));
               end
            end
            rsp_hold = calm ? 0 : $urandom_range(0, 3);
         end else if (rsp_valid && rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped at cycle limit %0d, %0d results outstanding",
                  CYCLE_LIMIT, pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int                        row;
      int                        n_random;
      int                        burst_left;
      int                        roll;
      int                        ins_cut;
      int                        rem_cut;
      traffic_mode_type          mode;
      logic [ils_pkg::ACT_W-1:0] ins_kind;
      step_row_type              s;

      // action, position, value, typed, {read_value, status, entry_total}
      directed_rows[0]  = '{ils_pkg::ACT_READ,   16'd0,    32'sd0,        1'b1,
                            '{ils_pkg::READ_ERR_VALUE, ils_pkg::ST_RANGE, 7'd0}};
      directed_rows[1]  = '{ils_pkg::ACT_REMOVE, 16'd0,    32'sd0,        1'b1,
                            '{32'sd0, ils_pkg::ST_RANGE, 7'd0}};
      directed_rows[2]  = '{ils_pkg::ACT_INSERT, 16'd1,    32'sd7,        1'b1,
                            '{32'sd0, ils_pkg::ST_RANGE, 7'd0}};
      directed_rows[3]  = '{ils_pkg::ACT_INSERT, 16'd0,    32'h7FFF_FFFF, 1'b1,
                            '{32'sd0, ils_pkg::ST_DONE, 7'd1}};
      directed_rows[4]  = '{ils_pkg::ACT_HEAD,   16'd0,    32'h8000_0000, 1'b1,
                            '{32'sd0, ils_pkg::ST_DONE, 7'd2}};
      directed_rows[5]  = '{ils_pkg::ACT_TAIL,   16'hFFFF, 32'sd0,        1'b1,
                            '{32'sd0, ils_pkg::ST_DONE, 7'd3}};
      directed_rows[6]  = '{ils_pkg::ACT_INSERT, 16'd3,    32'hFFFF_FFFF, 1'b1,
                            '{32'sd0, ils_pkg::ST_DONE, 7'd4}};
      directed_rows[7]  = '{ils_pkg::ACT_INSERT, 16'd1,    32'h5555_5555, 1'b0, NO_RESULT};
      directed_rows[8]  = '{ils_pkg::ACT_READ,   16'd0,    32'sd0,        1'b0, NO_RESULT};
      directed_rows[9]  = '{ils_pkg::ACT_READ,   16'd4,    32'sd0,        1'b0, NO_RESULT};
      directed_rows[10] = '{ils_pkg::ACT_READ,   16'hFFFF, 32'sd0,        1'b1,
                            '{ils_pkg::READ_ERR_VALUE, ils_pkg::ST_RANGE, 7'd5}};
      directed_rows[11] = '{ils_pkg::ACT_REMOVE, 16'hFFFF, 32'sd0,        1'b1,
                            '{32'sd0, ils_pkg::ST_RANGE, 7'd5}};
      directed_rows[12] = '{ils_pkg::ACT_INSERT, 16'hFFFF, 32'sd9,        1'b1,
                            '{32'sd0, ils_pkg::ST_RANGE, 7'd5}};
      directed_rows[13] = '{ACT_SPARE_LO,  16'hFFFF, 32'hAAAA_AAAA, 1'b1,
                            '{32'sd0, ils_pkg::ST_DONE, 7'd5}};
      directed_rows[14] = '{ACT_SPARE_MID, 16'd0,    32'sd0,        1'b1,
                            '{32'sd0, ils_pkg::ST_DONE, 7'd5}};
      directed_rows[15] = '{ACT_SPARE_HI,  16'd1,    32'sd1,        1'b1,
                            '{32'sd0, ils_pkg::ST_DONE, 7'd5}};
      directed_rows[16] = '{ils_pkg::ACT_REMOVE, 16'd0,    32'sd0,        1'b0, NO_RESULT};
      directed_rows[17] = '{ils_pkg::ACT_REMOVE, 16'd3,    32'sd0,        1'b0, NO_RESULT};
      directed_rows[18] = '{ils_pkg::ACT_READ,   16'd1,    32'sd0,        1'b0, NO_RESULT};
      directed_rows[19] = '{ils_pkg::ACT_INSERT, 16'd3,    32'sd1,        1'b0, NO_RESULT};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < N_ROWS; row++) begin
         issue_step(directed_rows[row]);
      end
      wait_drained();

      n_random = 0;
      burst_left = 0;
      mode = MODE_GROW;
      while (n_random < RANDOM_ITEMS) begin
         if (burst_left == 0) begin
            // first burst fills the store so the full path is exercised early
            if (n_random == 0) begin
               mode = MODE_GROW;
               burst_left = 140;
            end else begin
               if ($urandom_range(0, 2) == 0) wait_drained();
               mode = traffic_mode_type'($urandom_range(0, 2));
               burst_left = $urandom_range(60, 140);
            end
            calm = ($urandom_range(0, 3) == 0);
         end

         case ($urandom_range(0, 2))
            0:       ins_kind = ils_pkg::ACT_INSERT;
            1:       ins_kind = ils_pkg::ACT_HEAD;
            default: ins_kind = ils_pkg::ACT_TAIL;
         endcase
         case (mode)
            MODE_GROW:   begin ins_cut = 85; rem_cut = 93; end
            MODE_SHRINK: begin ins_cut = 20; rem_cut = 85; end
            default:     begin ins_cut = 35; rem_cut = 65; end
         endcase

         s = '0;
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            case ($urandom_range(0, 2))
               0:       s.action = ACT_SPARE_LO;
               1:       s.action = ACT_SPARE_MID;
               default: s.action = ACT_SPARE_HI;
            endcase
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < ins_cut) s.action = ins_kind;
            else if (roll < rem_cut) s.action = ils_pkg::ACT_REMOVE;
            else s.action = ils_pkg::ACT_READ;
         end

         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            if (s.action == ils_pkg::ACT_INSERT) begin
               s.position = ils_pkg::POS_W'($urandom_range(0, shadow_count));
            end else if (shadow_count > 0) begin
               s.position = ils_pkg::POS_W'($urandom_range(0, shadow_count - 1));
            end
         end else if (roll < 92) begin
            // hug the boundary: count, count + 1, count + 2
            s.position = ils_pkg::POS_W'(shadow_count + $urandom_range(0, 2));
         end else begin
            s.position = ils_pkg::POS_W'($urandom_range(0, 65535));
         end

         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0:       s.value = 32'h7FFF_FFFF;
               1:       s.value = 32'h8000_0000;
               2:       s.value = 32'hFFFF_FFFF;
               default: s.value = 32'sd0;
            endcase
         end else begin
            s.value = $urandom;
         end

         issue_step(s);
         burst_left--;
         if (s.action <= ils_pkg::ACT_REMOVE) n_random++;
      end

      calm = 1'b0;
      wait_drained();
      repeat (CAPACITY + 8) @(posedge clock);

      $display("covered %0d directed rows and %0d random requests; %0d results checked",
               N_ROWS, n_random, n_results);
      $display("list peaked at %0d of %0d entries; %0d full refusals, %0d range errors",
               peak_count, CAPACITY, n_full, n_range);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
